// ===== src/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list table package
// Shared widths, operation codes and control structures for the link table.
// ----------------------------------------------------------------------------
package dll_pkg;

    // Width of a node number and of one stored link.
    localparam int FIELD_W       = 11;
    localparam int KIND_W        = 2;
    localparam int NODES_DEFAULT = 1024;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 24;

    // Operation codes carried on the input tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_UNLINK = 2'd0,
        KIND_BEFORE = 2'd1,
        KIND_AFTER  = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    // Requests from the datapath to the sequencer.
    typedef struct packed {
        logic accept;
        logic query;
        logic hold;
    } seq_req_t;

    // Phase flags from the sequencer to the datapath.
    typedef struct packed {
        logic clearing;
        logic idle;
        logic read;
        logic write;
    } seq_ctl_t;

endpackage

// ===== src/doubly_linked_list_table_core.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list table core
// Previous and next link tables for nodes 1 to NODES, updated by unlink and
// insert operations and read back by queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry node_a in s_tdata[10:0], node_b in s_tdata[21:11] and
//   the operation in s_tuser[1:0]: unlink, insert before, insert after or
//   query. Only a query produces an output beat, with prev_node in
//   m_tdata[10:0] and next_node in m_tdata[21:11]; 0 means no neighbor.
//   The block works on one operation at a time. Both link memories are read
//   at the anchor when a beat is accepted. A query loads its result into the
//   output register in its read phase and then goes back to ready. Unlink and
//   insert write in the read phase and again in the write phase after it,
//   because each link memory has one write port and an operation writes up
//   to two entries in each.
//   After reset both link memories are cleared one entry per cycle, so
//   s_tready stays low until every entry has been cleared.
//   The result sits in an output register; while the receiver stalls the
//   block still takes and runs unlink and insert beats, and a query waits
//   in its read phase until the output register is free.
// ----------------------------------------------------------------------------
module doubly_linked_list_table_core
    import dll_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // node_a [10:0], node_b [21:11]
    input  logic [S_TUSER_W-1:0] s_tuser,   // kind [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // prev_node [10:0], next_node [21:11]
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int RW = $clog2(NODES + 1);
    localparam int CW = ((RW > AW ? RW : AW) > FIELD_W ? (RW > AW ? RW : AW) : FIELD_W) + 1;

    // True for a node number that names a table entry.
    function automatic logic node_ok(input logic [FIELD_W-1:0] n);
        return (n != '0) && (CW'(n) <= CW'(NODES));
    endfunction

    // Table entry of a node number.
    function automatic logic [AW-1:0] node_addr(input logic [FIELD_W-1:0] n);
        logic [CW-1:0] t;
        t = CW'(n) - CW'(1);
        return t[AW-1:0];
    endfunction

    seq_req_t           req;
    seq_ctl_t           ctl;
    logic [AW-1:0]      clr_addr;
    logic               s_accept;

    logic [FIELD_W-1:0] s_node_a, s_node_b;
    kind_t              kind_reg;
    logic [FIELD_W-1:0] a_reg, b_reg;
    logic               a_ok_reg, b_ok_reg;

    logic [FIELD_W-1:0] prev_rd, next_rd;
    logic               p_ok, n_ok, op_ok;

    logic               prev_we, next_we;
    logic [AW-1:0]      prev_waddr, next_waddr;
    logic [FIELD_W-1:0] prev_wdata, next_wdata;

    logic               out_load;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [FIELD_W-1:0] prev_out_reg, next_out_reg;

    // Input handshake.
    assign s_node_a = s_tdata[FIELD_W-1:0];
    assign s_node_b = s_tdata[2*FIELD_W-1:FIELD_W];
    assign s_tready = ctl.idle;
    assign s_accept = s_tvalid && s_tready;

    // Capture the operation of an accepted beat.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= kind_t'(s_tuser[KIND_W-1:0]);
            a_reg    <= s_node_a;
            b_reg    <= s_node_b;
            a_ok_reg <= node_ok(s_node_a);
            b_ok_reg <= node_ok(s_node_b) && (s_node_b != s_node_a);
        end
    end

    // Sequencer.
    assign req.accept = s_accept;
    assign req.query  = (kind_reg == KIND_QUERY);
    assign req.hold   = m_tvalid_reg && !m_tready;

    dll_seq #(
        .NODES (NODES),
        .AW    (AW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .ctl      (ctl),
        .clr_addr (clr_addr)
    );

    // Link memories, both read at the anchor when a beat is accepted.
    dll_ram #(
        .DEPTH (NODES),
        .AW    (AW)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (s_accept),
        .raddr (node_addr(s_node_a)),
        .rdata (prev_rd)
    );

    dll_ram #(
        .DEPTH (NODES),
        .AW    (AW)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (s_accept),
        .raddr (node_addr(s_node_a)),
        .rdata (next_rd)
    );

    // Neighbor checks on the anchor's links.
    assign p_ok = node_ok(prev_rd);
    assign n_ok = node_ok(next_rd);

    always_comb begin
        case (kind_reg)
            KIND_UNLINK: op_ok = a_ok_reg;
            KIND_BEFORE: op_ok = a_ok_reg && b_ok_reg;
            KIND_AFTER:  op_ok = a_ok_reg && b_ok_reg;
            default:     op_ok = 1'b0;
        endcase
    end

    // Write ports. The first write phase runs with the read data, the second
    // one in the cycle after it; a later write to the same entry wins.
    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = node_addr(a_reg);
        prev_wdata = '0;
        next_we    = 1'b0;
        next_waddr = node_addr(a_reg);
        next_wdata = '0;
        if (ctl.clearing) begin
            prev_we    = 1'b1;
            prev_waddr = clr_addr;
            next_we    = 1'b1;
            next_waddr = clr_addr;
        end else if (ctl.read && op_ok) begin
            case (kind_reg)
                KIND_UNLINK: begin
                    prev_we    = n_ok;
                    prev_waddr = node_addr(next_rd);
                    prev_wdata = prev_rd;
                    next_we    = p_ok;
                    next_waddr = node_addr(prev_rd);
                    next_wdata = next_rd;
                end
                KIND_BEFORE: begin
                    prev_we    = p_ok;
                    prev_waddr = node_addr(b_reg);
                    prev_wdata = prev_rd;
                    next_we    = 1'b1;
                    next_waddr = node_addr(b_reg);
                    next_wdata = a_reg;
                end
                KIND_AFTER: begin
                    prev_we    = 1'b1;
                    prev_waddr = node_addr(b_reg);
                    prev_wdata = a_reg;
                    next_we    = n_ok;
                    next_waddr = node_addr(b_reg);
                    next_wdata = next_rd;
                end
                default: begin
                    prev_we = 1'b0;
                    next_we = 1'b0;
                end
            endcase
        end else if (ctl.write && op_ok) begin
            case (kind_reg)
                KIND_UNLINK: begin
                    prev_we = 1'b1;
                    next_we = 1'b1;
                end
                KIND_BEFORE: begin
                    prev_we    = 1'b1;
                    prev_wdata = b_reg;
                    next_we    = p_ok;
                    next_waddr = node_addr(prev_rd);
                    next_wdata = b_reg;
                end
                KIND_AFTER: begin
                    prev_we    = n_ok;
                    prev_waddr = node_addr(next_rd);
                    prev_wdata = b_reg;
                    next_we    = 1'b1;
                    next_wdata = b_reg;
                end
                default: begin
                    prev_we = 1'b0;
                    next_we = 1'b0;
                end
            endcase
        end
    end

    // Output register for query results.
    assign out_load = ctl.read && req.query && !req.hold;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            prev_out_reg <= a_ok_reg ? prev_rd : '0;
            next_out_reg <= a_ok_reg ? next_rd : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*FIELD_W){1'b0}}, next_out_reg, prev_out_reg};

`ifndef SYNTHESIS
    // No table entry changes while the block waits for a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.idle |-> (!prev_we && !next_we))
        else $error("link write while idle");

    // A result appears only after the read phase of a query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(ctl.read) && $past(kind_reg == KIND_QUERY)))
        else $error("result without a query read");

    // Link writes always land inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!prev_we || (prev_waddr <= AW'(NODES - 1))) &&
        (!next_we || (next_waddr <= AW'(NODES - 1))))
        else $error("link write outside the table");

    // Queries never write the tables.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((ctl.read || ctl.write) && (kind_reg == KIND_QUERY)) |-> (!prev_we && !next_we))
        else $error("query wrote a link");
`endif

endmodule

// ===== src/dll_ram.sv =====
// ----------------------------------------------------------------------------
// Link memory
// Single write port, single read port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dll_ram
    import dll_pkg::*;
#(
    parameter int DEPTH = NODES_DEFAULT,
    parameter int AW    = 10
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [FIELD_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [FIELD_W-1:0] rdata
);

    logic [FIELD_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/dll_seq.sv =====
// ----------------------------------------------------------------------------
// Operation sequencer
// Runs the clearing pass after reset and steps each operation through its
// read phase and, for unlink and insert, its write phase.
// ----------------------------------------------------------------------------
module dll_seq
    import dll_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  seq_req_t      req,
    output seq_ctl_t      ctl,
    output logic [AW-1:0] clr_addr
);

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Next state.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req.accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (!req.query) begin
                    state_next = ST_WRITE;
                end else if (!req.hold) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Phase flags.
    assign ctl.clearing = (state_reg == ST_CLEAR);
    assign ctl.idle     = (state_reg == ST_IDLE);
    assign ctl.read     = (state_reg == ST_READ);
    assign ctl.write    = (state_reg == ST_WRITE);
    assign clr_addr     = clr_cnt_reg;

`ifndef SYNTHESIS
    // An operation reaches its second write phase only straight from its read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.write |-> $past(ctl.read))
        else $error("write phase entered without a read phase");

    // An accepted beat always starts a read phase next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.idle && req.accept) |=> ctl.read)
        else $error("accepted beat did not start a read");
`endif

endmodule

// ===== test/doubly_linked_list_table_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Doubly linked list table core testbench
// Drives unlink, insert and query beats into the link table. A local copy of
// the previous and next link tables predicts the neighbors that each query
// returns, and every output beat is checked against those predictions in
// order. The stimulus builds and tears down real lists over a small working
// set of nodes, and mixes in out-of-range, self-insert and random operations.
// Both sides pause in random bursts, and the receiver stalls once for a long
// stretch so that queries back up into the input.
// ----------------------------------------------------------------------------
module doubly_linked_list_table_core_test;
    import dll_pkg::*;

    localparam int NODES     = NODES_DEFAULT;
    localparam int RAND_OPS  = 1600;
    localparam int TAIL_OPS  = 200;
    localparam int LONG_HOLD = 300;
    // The stimulus planner and the checker each keep a copy of the tables.
    localparam int VIEW_PLAN = 0;
    localparam int VIEW_LIVE = 1;

    typedef logic [FIELD_W-1:0] node_t;

    typedef struct packed {
        kind_t kind;
        node_t node_a;
        node_t node_b;
    } list_op_t;

    typedef struct packed {
        node_t prev_node;
        node_t next_node;
    } neighbors_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Link tables, indexed by view and then by node number.
    node_t link_prev [2][NODES+1];
    node_t link_next [2][NODES+1];

    list_op_t   op_q[$];
    neighbors_t neighbor_q[$];
    list_op_t   cur_op;

    int unsigned total_ops    = 0;
    int unsigned beats_in     = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned unlink_cnt   = 0;
    int unsigned insert_cnt   = 0;
    int unsigned query_cnt    = 0;
    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        idle_on      = 1'b1;

    doubly_linked_list_table_core #(
        .NODES(NODES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Apply one operation to one view of the tables; returns 1 for a query.
    function automatic bit apply_list_op(input int view, input list_op_t op,
                                         output neighbors_t found);
        node_t p;
        node_t n;
        bit    a_ok;
        bit    b_ok;
        a_ok  = (op.node_a >= 1) && (op.node_a <= NODES);
        b_ok  = (op.node_b >= 1) && (op.node_b <= NODES) && (op.node_b != op.node_a);
        found = '0;
        case (op.kind)
            KIND_UNLINK: begin
                if (a_ok) begin
                    p = link_prev[view][op.node_a];
                    n = link_next[view][op.node_a];
                    if (n != 0) link_prev[view][n] = p;
                    if (p != 0) link_next[view][p] = n;
                    link_prev[view][op.node_a] = '0;
                    link_next[view][op.node_a] = '0;
                end
            end
            KIND_BEFORE: begin
                if (a_ok && b_ok) begin
                    p = link_prev[view][op.node_a];
                    link_next[view][op.node_b] = op.node_a;
                    if (p != 0) begin
                        link_prev[view][op.node_b] = p;
                        link_next[view][p] = op.node_b;
                    end
                    link_prev[view][op.node_a] = op.node_b;
                end
            end
            KIND_AFTER: begin
                if (a_ok && b_ok) begin
                    n = link_next[view][op.node_a];
                    link_prev[view][op.node_b] = op.node_a;
                    if (n != 0) begin
                        link_next[view][op.node_b] = n;
                        link_prev[view][n] = op.node_b;
                    end
                    link_next[view][op.node_a] = op.node_b;
                end
            end
            default: begin
                if (a_ok) begin
                    found.prev_node = link_prev[view][op.node_a];
                    found.next_node = link_next[view][op.node_a];
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Queue one operation for the driver and track it in the planning view.
    task automatic plan_op(input kind_t kind, input int a, input int b);
        list_op_t   op;
        neighbors_t unused;
        op.kind   = kind;
        op.node_a = node_t'(a);
        op.node_b = node_t'(b);
        void'(apply_list_op(VIEW_PLAN, op, unused));
        op_q.push_back(op);
        total_ops++;
    endtask

    // Nodes of the working set: mostly low numbers, some at the top end.
    function automatic int pick_node();
        if ($urandom_range(0, 4) == 0) return $urandom_range(NODES - 15, NODES);
        return $urandom_range(1, 40);
    endfunction

    // Stimulus plan, reset and end of run.
    initial begin
        int r;
        int a;
        int b;
        int tries;
        bit found_lone;
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i <= NODES; i++) begin
                link_prev[v][i] = '0;
                link_next[v][i] = '0;
            end
        end

        // Directed part: lone and out-of-range queries, edge node numbers,
        // ignored operations, a short list built and cut, and a non-lone insert.
        plan_op(KIND_QUERY, 1, 0);
        plan_op(KIND_QUERY, NODES, 0);
        plan_op(KIND_QUERY, 0, 0);
        plan_op(KIND_QUERY, 2047, 2047);
        plan_op(KIND_UNLINK, 7, 0);
        plan_op(KIND_UNLINK, 0, 5);
        plan_op(KIND_UNLINK, 2047, 0);
        plan_op(KIND_AFTER, 1, 2);
        plan_op(KIND_BEFORE, 1, NODES);
        plan_op(KIND_AFTER, 1, 3);
        plan_op(KIND_BEFORE, 0, 5);
        plan_op(KIND_AFTER, 4, 0);
        plan_op(KIND_AFTER, 4, NODES + 1);
        plan_op(KIND_BEFORE, 6, 6);
        plan_op(KIND_QUERY, 1, 0);
        plan_op(KIND_QUERY, 3, 0);
        plan_op(KIND_QUERY, NODES, 0);
        plan_op(KIND_QUERY, 2, 0);
        plan_op(KIND_UNLINK, 1, 0);
        plan_op(KIND_QUERY, 3, 0);
        plan_op(KIND_QUERY, NODES, 0);
        plan_op(KIND_BEFORE, 2, NODES);
        plan_op(KIND_QUERY, 2, 0);
        plan_op(KIND_QUERY, NODES, 0);
        plan_op(KIND_QUERY, 3, 0);

        // Random part: mostly well-formed list edits, with some raw noise.
        for (int i = 0; i < RAND_OPS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                plan_op(kind_t'($urandom_range(0, 3)), $urandom_range(0, 2047),
                        $urandom_range(0, 2047));
            end else begin
                a = pick_node();
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    found_lone = 1'b0;
                    b = 0;
                    tries = 0;
                    while (!found_lone && tries < 8) begin
                        b = pick_node();
                        found_lone = (b != a) && (link_prev[VIEW_PLAN][b] == 0)
                                     && (link_next[VIEW_PLAN][b] == 0);
                        tries++;
                    end
                    if (found_lone)
                        plan_op($urandom_range(0, 1) ? KIND_BEFORE : KIND_AFTER, a, b);
                    else
                        plan_op(KIND_UNLINK, a, $urandom_range(0, 2047));
                end else if (r < 65) begin
                    plan_op(KIND_UNLINK, a, $urandom_range(0, 2047));
                end else begin
                    plan_op(KIND_QUERY, a, $urandom_range(0, 2047));
                end
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_in < total_ops) @(posedge aclk);
        while (neighbor_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d operations: %0d unlinks, %0d inserts, %0d queries.",
                 beats_in, unlink_cnt, insert_cnt, query_cnt);
        $display("Checked %0d neighbor results, %0d mismatching fields.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Toggles between stretches with and without idling.
    always @(posedge aclk) begin
        if ($urandom_range(0, 59) == 0) idle_on <= ~idle_on;
    end

    // Input driver: predicts each accepted beat, then offers the next one.
    always @(posedge aclk) begin
        neighbors_t found;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (apply_list_op(VIEW_LIVE, cur_op, found)) neighbor_q.push_back(found);
                case (cur_op.kind)
                    KIND_UNLINK: unlink_cnt++;
                    KIND_QUERY:  query_cnt++;
                    default:     insert_cnt++;
                endcase
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (op_q.size() != 0) begin
                    cur_op   <= op_q[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - 2 * FIELD_W){1'b0}}, op_q[0].node_b,
                                 op_q[0].node_a};
                    s_tuser  <= {{(S_TUSER_W - KIND_W){1'b0}}, op_q[0].kind};
                    void'(op_q.pop_front());
                    if (idle_on && op_q.size() > TAIL_OPS && $urandom_range(0, 4) == 0)
                        tx_gap <= $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver stall once enough results have passed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 60) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // Output monitor: checks each result beat against the oldest prediction.
    always @(posedge aclk) begin
        neighbors_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (neighbor_q.size() == 0) begin
                    $error("Result beat with no query pending: prev_node %0d, next_node %0d",
                           m_tdata[FIELD_W-1:0], m_tdata[2*FIELD_W-1:FIELD_W]);
                    mismatches++;
                end else begin
                    want = neighbor_q.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== want.prev_node) begin
                        $error("prev_node mismatch: expected %0d, got %0d",
                               want.prev_node, m_tdata[FIELD_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.next_node) begin
                        $error("next_node mismatch: expected %0d, got %0d",
                               want.next_node, m_tdata[2*FIELD_W-1:FIELD_W]);
                        mismatches++;
                    end
                end
            end
            if (rx_gap != 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (idle_on && op_q.size() > TAIL_OPS && $urandom_range(0, 5) == 0) begin
                rx_gap   <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

endmodule

// ===== doubly_linked_list_table_core.f =====
src/dll_pkg.sv
src/dll_ram.sv
src/dll_seq.sv
src/doubly_linked_list_table_core.sv
test/doubly_linked_list_table_core_test.sv
